FILE: rtl/pmb_pkg.sv
package pmb_pkg;

  localparam int METERS_DEFAULT = 4;
  localparam int QUEUE_DEPTH    = 2;

  localparam int MAG_W   = 24;
  localparam int LEVEL_W = 16;
  localparam int OUT_W   = 15;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // 1/256 dB per 1/256 octave, times 256
  localparam int LVL_SCALE = 1541;
  localparam int LVL_ROUND = 128;

  localparam logic [CFG_IDX_W-1:0] REG_BAR_FALL_STEP    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_FALL_STEP = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL      = 4'd3;

  localparam logic [11:0] BAR_FALL_RESET    = 12'd492;
  localparam logic [11:0] MARKER_FALL_RESET = 12'd113;
  localparam logic [7:0]  HOLD_TICKS_RESET  = 8'd30;
  localparam logic signed [14:0] FLOOR_RESET = -15'sd15360;

  typedef struct packed {
    logic [11:0]        bar_fall_step;
    logic [11:0]        marker_fall_step;
    logic [7:0]         hold_ticks;
    logic signed [14:0] floor_level;
  } cfg_t;

  // round(256 * log2(1 + i/64))
  localparam logic [7:0] FRAC_TABLE [64] = '{
    8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
    8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
    8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
    8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
    8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
    8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
    8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
    8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
  };

endpackage

FILE: rtl/pmb_fifo.sv
module pmb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import pmb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("fifo written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("fifo read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("fifo count out of range");
`endif

endmodule

FILE: rtl/pmb_front.sv
module pmb_front #(
  parameter int METERS = pmb_pkg::METERS_DEFAULT,
  parameter int MIDX_W = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         meter_index,
  input  logic [pmb_pkg::MAG_W-1:0]          peak_magnitude,
  output logic                               item_valid,
  output logic [MIDX_W-1:0]                  item_idx,
  output logic                               item_low,
  output logic signed [pmb_pkg::LEVEL_W-1:0] item_level,
  input  logic                               item_full
);
  import pmb_pkg::*;

  logic              adv;
  logic              in_range;
  logic [4:0]        lo_pos;
  logic [MAG_W-1:0]  norm;

  logic              s1_valid;
  logic [MIDX_W-1:0] s1_idx;
  logic              s1_low;
  logic [4:0]        s1_pos;
  logic [5:0]        s1_frac_idx;

  logic signed [5:0]  oct;
  logic signed [13:0] log_val;
  logic signed [25:0] prod;
  logic signed [25:0] rounded;

  logic                      s2_valid;
  logic [MIDX_W-1:0]         s2_idx;
  logic                      s2_low;
  logic signed [LEVEL_W-1:0] s2_level;

  // the pipe moves whenever the last stage can drain into the queue
  assign adv      = !s2_valid || !item_full;
  assign full     = !adv;
  assign in_range = ({30'd0, meter_index} < 32'(METERS));

  always_comb begin
    lo_pos = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (peak_magnitude[k]) begin
        lo_pos = 5'(k);
      end
    end
    norm = peak_magnitude << (5'd23 - lo_pos);
  end

  always_comb begin
    oct     = $signed({1'b0, s1_pos}) - 6'sd23;
    log_val = $signed({oct, 8'd0}) + $signed({6'd0, FRAC_TABLE[s1_frac_idx]});
    prod    = 26'(log_val) * 26'(LVL_SCALE);
    rounded = prod + 26'(LVL_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push && in_range;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx      <= MIDX_W'(meter_index);
      s1_low      <= (peak_magnitude <= 24'd8);
      s1_pos      <= lo_pos;
      s1_frac_idx <= norm[22:17];
      s2_idx      <= s1_idx;
      s2_low      <= s1_low;
      s2_level    <= LEVEL_W'(rounded >>> 8);
    end
  end

  assign item_valid = s2_valid;
  assign item_idx   = s2_idx;
  assign item_low   = s2_low;
  assign item_level = s2_level;

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
      s2_valid && item_full |=> s2_valid && $stable(s2_level) && $stable(s2_idx))
    else $error("front item lost while queue full");
  a_full_only_when_loaded: assert property (@(posedge clk) disable iff (rst)
      full |-> s2_valid)
    else $error("front stalls with empty last stage");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
      s2_valid && !s2_low |-> s2_level <= 16'sd1541)
    else $error("level above full scale");
`endif

endmodule

FILE: rtl/pmb_back.sv
module pmb_back #(
  parameter int METERS = pmb_pkg::METERS_DEFAULT,
  parameter int MIDX_W = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pmb_pkg::cfg_t                      cfg,
  input  logic                               item_valid,
  input  logic [MIDX_W-1:0]                  item_idx,
  input  logic                               item_low,
  input  logic signed [pmb_pkg::LEVEL_W-1:0] item_level,
  output logic                               item_pop,
  input  logic                               res_full,
  output logic                               res_push,
  output logic signed [pmb_pkg::OUT_W-1:0]   res_bar,
  output logic signed [pmb_pkg::OUT_W-1:0]   res_marker,
  output logic                               res_at_floor
);
  import pmb_pkg::*;

  logic signed [LEVEL_W-1:0] bar_q    [METERS];
  logic signed [LEVEL_W-1:0] marker_q [METERS];
  logic [7:0]                cd_q     [METERS];

  logic                      fire;
  logic signed [16:0]        flr;
  logic signed [16:0]        v;
  logic signed [16:0]        bar_old;
  logic signed [16:0]        mk_old;
  logic [7:0]                cd_old;
  logic signed [16:0]        bar_dec;
  logic signed [16:0]        bar_mid;
  logic signed [16:0]        bar_new;
  logic signed [16:0]        mk_dec;
  logic signed [16:0]        mk_mid;
  logic signed [16:0]        mk_new;
  logic [7:0]                cd_new;

  assign fire     = item_valid && !res_full;
  assign item_pop = fire;
  assign res_push = fire;

  always_comb begin
    flr     = 17'(cfg.floor_level);
    v       = item_low ? flr : 17'(item_level);
    bar_old = 17'(bar_q[item_idx]);
    mk_old  = 17'(marker_q[item_idx]);
    cd_old  = cd_q[item_idx];

    // bar: instant attack, fixed-step release, never under the level
    bar_dec = bar_old - $signed({5'd0, cfg.bar_fall_step});
    if (v > bar_old) begin
      bar_mid = v;
    end else begin
      bar_mid = (bar_dec < v) ? v : bar_dec;
    end
    bar_new = (bar_mid < flr) ? flr : bar_mid;

    // marker: capture, hold for a number of ticks, then fall toward the bar
    mk_dec = mk_old - $signed({5'd0, cfg.marker_fall_step});
    cd_new = cd_old;
    if (v >= mk_old) begin
      mk_mid = v;
      cd_new = cfg.hold_ticks;
    end else if (cd_old == 8'd0) begin
      mk_mid = (mk_dec < bar_new) ? bar_new : mk_dec;
    end else begin
      mk_mid = mk_old;
      cd_new = cd_old - 8'd1;
    end
    mk_new = (mk_mid < flr) ? flr : mk_mid;
  end

  assign res_bar      = OUT_W'(bar_new);
  assign res_marker   = OUT_W'(mk_new);
  assign res_at_floor = (mk_new <= flr);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < METERS; k++) begin
        bar_q[k]    <= LEVEL_W'(FLOOR_RESET);
        marker_q[k] <= LEVEL_W'(FLOOR_RESET);
        cd_q[k]     <= 8'd0;
      end
    end else if (fire) begin
      bar_q[item_idx]    <= LEVEL_W'(bar_new);
      marker_q[item_idx] <= LEVEL_W'(mk_new);
      cd_q[item_idx]     <= cd_new;
    end
  end

`ifndef SYNTHESIS
  a_bar_floor: assert property (@(posedge clk) disable iff (rst)
      fire |-> bar_new >= flr)
    else $error("bar below floor");
  a_marker_floor: assert property (@(posedge clk) disable iff (rst)
      fire |-> mk_new >= flr && res_at_floor == (mk_new == flr))
    else $error("marker below floor");
  a_capture_rearms: assert property (@(posedge clk) disable iff (rst)
      fire && v >= mk_old |-> cd_new == cfg.hold_ticks && mk_mid == v)
    else $error("marker capture did not rearm hold");
`endif

endmodule

FILE: rtl/peak_meter_ballistics_core.sv
// Peak meter ballistics for a small set of meters (default four).
// Input queue side: drive meter_index and peak_magnitude (unsigned Q1.23) with
// push; a transfer happens on a clock edge with push high and full low. Items
// for a meter index at or beyond METERS are dropped and give no result.
// Result queue side: while empty is low, bar_level, marker_level and
// marker_at_floor show the oldest result; pop high on an edge transfers it.
// One result per in-range item, in input order.
// A result passes both front stages, the middle queue and the per-meter update
// into the result queue. Throughput: one item per cycle while full is low; the
// level conversion is a two-stage pipe (leading-one/normalize, then table plus
// one multiply) and the per-meter update is a read-modify-write on flip-flop state.
// When pop is held low the result queue fills, then the middle queue, then
// the front pipe, and full rises; nothing is lost.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 bar
// fall step, 1 marker fall step, 2 hold ticks, 3 floor level; other indexes
// are ignored. Write only while the block is idle.
// Reset (synchronous, rst high) restores register defaults, puts every bar and
// marker at -60 dB, clears hold counters and empties all queues.
module peak_meter_ballistics_core #(
  parameter int METERS = pmb_pkg::METERS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            meter_index,
  input  logic [pmb_pkg::MAG_W-1:0]             peak_magnitude,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [pmb_pkg::OUT_W-1:0]      bar_level,
  output logic signed [pmb_pkg::OUT_W-1:0]      marker_level,
  output logic                                  marker_at_floor,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pmb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pmb_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pmb_pkg::*;

  localparam int MIDX_W  = (METERS > 1) ? $clog2(METERS) : 1;
  localparam int MID_W   = MIDX_W + 1 + LEVEL_W;
  localparam int RES_W   = 2 * OUT_W + 1;

  cfg_t cfg;

  logic                      f_valid;
  logic [MIDX_W-1:0]         f_idx;
  logic                      f_low;
  logic signed [LEVEL_W-1:0] f_level;
  logic                      mid_full;
  logic                      mid_empty;
  logic                      mid_push;
  logic                      mid_pop;
  logic [MID_W-1:0]          mid_rdata;

  logic                      res_full;
  logic                      res_push;
  logic signed [OUT_W-1:0]   res_bar;
  logic signed [OUT_W-1:0]   res_marker;
  logic                      res_at_floor;
  logic [RES_W-1:0]          res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bar_fall_step    <= BAR_FALL_RESET;
      cfg.marker_fall_step <= MARKER_FALL_RESET;
      cfg.hold_ticks       <= HOLD_TICKS_RESET;
      cfg.floor_level      <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BAR_FALL_STEP:    cfg.bar_fall_step    <= cfg_data[11:0];
        REG_MARKER_FALL_STEP: cfg.marker_fall_step <= cfg_data[11:0];
        REG_HOLD_TICKS:       cfg.hold_ticks       <= cfg_data[7:0];
        REG_FLOOR_LEVEL:      cfg.floor_level      <= $signed(cfg_data[14:0]);
        default: ;
      endcase
    end
  end

  pmb_front #(
    .METERS (METERS),
    .MIDX_W (MIDX_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .meter_index    (meter_index),
    .peak_magnitude (peak_magnitude),
    .item_valid     (f_valid),
    .item_idx       (f_idx),
    .item_low       (f_low),
    .item_level     (f_level),
    .item_full      (mid_full)
  );

  assign mid_push = f_valid && !mid_full;

  pmb_fifo #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata ({f_idx, f_low, f_level}),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  pmb_back #(
    .METERS (METERS),
    .MIDX_W (MIDX_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (!mid_empty),
    .item_idx     (mid_rdata[MID_W-1 -: MIDX_W]),
    .item_low     (mid_rdata[LEVEL_W]),
    .item_level   ($signed(mid_rdata[LEVEL_W-1:0])),
    .item_pop     (mid_pop),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_bar      (res_bar),
    .res_marker   (res_marker),
    .res_at_floor (res_at_floor)
  );

  pmb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata ({res_bar, res_marker, res_at_floor}),
    .full  (res_full),
    .pop   (pop && !empty),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign bar_level       = $signed(res_rdata[RES_W-1 -: OUT_W]);
  assign marker_level    = $signed(res_rdata[OUT_W:1]);
  assign marker_at_floor = res_rdata[0];

endmodule

FILE: sim/pmb_checker.sv
module pmb_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic                             full,
  input  logic [1:0]                       meter_index,
  input  logic [pmb_pkg::MAG_W-1:0]        peak_magnitude,
  input  logic                             empty,
  input  logic                             pop,
  input  logic signed [pmb_pkg::OUT_W-1:0] bar_level,
  input  logic signed [pmb_pkg::OUT_W-1:0] marker_level,
  input  logic                             marker_at_floor,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [pmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                               fail_count,
  output int                               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import pmb_pkg::*;

  localparam int NUM_METERS = 4;

  typedef struct packed {
    logic [OUT_W-1:0] bar;
    logic [OUT_W-1:0] marker;
    logic             at_floor;
  } meter_reading_t;

  // round(256 * log2(1 + i/64))
  int log_frac [64] = '{
      0,   6,  11,  17,  22,  28,  33,  38,  44,  49,  54,  59,  63,  68,  73,  78,
     82,  87,  92,  96, 100, 105, 109, 113, 118, 122, 126, 130, 134, 138, 142, 146,
    150, 154, 157, 161, 165, 169, 172, 176, 179, 183, 186, 190, 193, 197, 200, 203,
    207, 210, 213, 216, 220, 223, 226, 229, 232, 235, 238, 241, 244, 247, 250, 253
  };

  cfg_t           regs;
  int             bar_db    [NUM_METERS];
  int             marker_db [NUM_METERS];
  logic [7:0]     hold_left [NUM_METERS];
  meter_reading_t readings_due [$];
  int             errors = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic int level_in_db(logic [MAG_W-1:0] x);
    int p;
    int idx;
    int xv;
    int l;
    if (x <= 8) return int'(regs.floor_level);
    xv = int'(x);
    p = 23;
    while (p > 0 && !x[p]) p--;
    if (p >= 6) idx = (xv >> (p - 6)) & 63;
    else idx = (xv << (6 - p)) & 63;
    l = (p - 23) * 256 + log_frac[idx];
    // arithmetic shift floors the negative values
    return (l * 1541 + 128) >>> 8;
  endfunction

  function automatic meter_reading_t advance_meter(int m, int v);
    meter_reading_t r;
    int bar;
    int mk;
    int fl;
    fl  = int'(regs.floor_level);
    bar = bar_db[m];
    if (v > bar) begin
      bar = v;
    end else begin
      bar = bar - int'(regs.bar_fall_step);
      if (bar < v) bar = v;
    end
    if (bar < fl) bar = fl;

    mk = marker_db[m];
    if (v >= mk) begin
      mk = v;
      hold_left[m] = regs.hold_ticks;
    end else if (hold_left[m] == 8'd0) begin
      mk = mk - int'(regs.marker_fall_step);
      if (mk < bar) mk = bar;
    end else begin
      hold_left[m] = hold_left[m] - 8'd1;
    end
    if (mk < fl) mk = fl;

    bar_db[m]    = bar;
    marker_db[m] = mk;
    r.bar      = bar[OUT_W-1:0];
    r.marker   = mk[OUT_W-1:0];
    r.at_floor = (mk <= fl);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    meter_reading_t want;
    if (rst) begin
      regs.bar_fall_step    = BAR_FALL_RESET;
      regs.marker_fall_step = MARKER_FALL_RESET;
      regs.hold_ticks       = HOLD_TICKS_RESET;
      regs.floor_level      = FLOOR_RESET;
      for (int k = 0; k < NUM_METERS; k++) begin
        bar_db[k]    = int'(FLOOR_RESET);
        marker_db[k] = int'(FLOOR_RESET);
        hold_left[k] = 8'd0;
      end
      readings_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BAR_FALL_STEP:    regs.bar_fall_step    = cfg_data[11:0];
          REG_MARKER_FALL_STEP: regs.marker_fall_step = cfg_data[11:0];
          REG_HOLD_TICKS:       regs.hold_ticks       = cfg_data[7:0];
          REG_FLOOR_LEVEL:      regs.floor_level      = cfg_data[14:0];
          default: ;
        endcase
      end

      if (pop && !empty) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result transfer with none due, bar_level", int'(bar_level), 0);
        end else begin
          want = readings_due.pop_front();
          if (bar_level !== want.bar)
            report_mismatch("bar_level", int'(bar_level), int'(signed'(want.bar)));
          if (marker_level !== want.marker)
            report_mismatch("marker_level", int'(marker_level), int'(signed'(want.marker)));
          if (marker_at_floor !== want.at_floor)
            report_mismatch("marker_at_floor", int'(marker_at_floor), int'(want.at_floor));
        end
      end

      if (push && !full)
        readings_due.push_back(advance_meter(int'(meter_index), level_in_db(peak_magnitude)));
    end
    outstanding <= readings_due.size();
    fail_count  <= errors;
  end

endmodule

FILE: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  logic [1:0]              meter_index = 2'd0;
  logic [MAG_W-1:0]        peak_magnitude = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [OUT_W-1:0] bar_level;
  logic signed [OUT_W-1:0] marker_level;
  logic                    marker_at_floor;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  int fail_count;
  int outstanding;
  int send_idle_pct = 14;
  int take_idle_pct = 14;
  int hold_off_left = 0;
  int hold_off_len = 0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int cycles = 0;
  logic [MAG_W-1:0] envelope [4];

  peak_meter_ballistics_core dut (.*);
  pmb_checker checker_i (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off_seen != hold_off_reqs) begin
      pop <= 1'b0;
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= hold_off_len - 1;
    end else if (hold_off_left > 0) begin
      pop <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  function automatic logic [MAG_W-1:0] log_magnitude();
    int p;
    logic [MAG_W-1:0] one;
    p = $urandom_range(23);
    one = 24'd1 << p;
    return one | (24'($urandom) & (one - 24'd1));
  endfunction

  function automatic logic [MAG_W-1:0] random_magnitude(int m);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 24'($urandom_range(8));
    if (r < 20) return 24'($urandom);
    if (r < 40) return log_magnitude();
    // decaying envelope per meter so bars fall and holds run out
    if ($urandom_range(19) == 0) envelope[m] = log_magnitude();
    else envelope[m] = envelope[m] - (envelope[m] >> $urandom_range(5, 2));
    return envelope[m];
  endfunction

  task automatic send_tick(input logic [1:0] m, input logic [MAG_W-1:0] mag);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push           <= 1'b1;
    meter_index    <= m;
    peak_magnitude <= mag;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // upper data bits beyond each register are random and must be ignored
  task automatic configure(input int bar_step, input int mk_step, input int hold, input int fl);
    logic [CFG_IDX_W-1:0] junk_idx;
    junk_idx = 4'($urandom_range(15, 4));
    write_reg(REG_BAR_FALL_STEP, {4'($urandom), 12'(bar_step)});
    write_reg(REG_MARKER_FALL_STEP, {4'($urandom), 12'(mk_step)});
    write_reg(REG_HOLD_TICKS, {8'($urandom), 8'(hold)});
    write_reg(REG_FLOOR_LEVEL, {1'($urandom), 15'(fl)});
    write_reg(junk_idx, 16'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int bar_step, input int mk_step, input int hold, input int fl,
                           input int count, input int hold_off);
    drain();
    configure(bar_step, mk_step, hold, fl);
    if (hold_off > 0) begin
      hold_off_len  <= hold_off;
      hold_off_reqs <= hold_off_reqs + 1;
    end
    for (int n = 0; n < count; n++) begin
      int m;
      m = $urandom_range(3);
      if (n == count / 2) drain();
      send_tick(2'(m), random_magnitude(m));
    end
  endtask

  initial begin
    for (int k = 0; k < 4; k++) envelope[k] = 24'h7FFFFF;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // level conversion edges, then a loud tick followed by quiet ones
    send_tick(2'd0, 24'd0);
    send_tick(2'd1, 24'd8);
    send_tick(2'd2, 24'd9);
    send_tick(2'd3, 24'd15);
    send_tick(2'd0, 24'd16);
    send_tick(2'd1, 24'd63);
    send_tick(2'd2, 24'd64);
    send_tick(2'd3, 24'd127);
    send_tick(2'd0, 24'hFFFFFF);
    send_tick(2'd0, 24'h000010);
    send_tick(2'd0, 24'h000010);
    send_tick(2'd1, 24'h800000);
    send_tick(2'd1, 24'h7FFFFF);
    send_tick(2'd2, 24'h400000);
    send_tick(2'd3, 24'h555555);
    send_tick(2'd3, 24'hAAAAAA);
    send_tick(2'd2, 24'd1);
    send_tick(2'd2, 24'h000100);
    send_tick(2'd1, 24'h000041);
    send_tick(2'd1, 24'h00007F);
    // no hold: the marker starts falling on the very next quiet tick
    drain();
    configure(492, 113, 0, -15360);
    send_tick(2'd0, 24'hFFFFFF);
    send_tick(2'd0, 24'h000200);
    send_tick(2'd0, 24'h000200);
    send_tick(2'd0, 24'd3);

    run_phase(492, 113, 30, -15360, 200, 80);
    run_phase(0, 0, 0, -16384, 100, 0);
    run_phase(4095, 4095, 255, 0, 100, 0);
    run_phase(4095, 0, 3, -16384, 100, 0);
    send_idle_pct = 0;
    take_idle_pct = 0;
    run_phase(64, 32, 2, -7680, 200, 0);
    send_idle_pct = 14;
    take_idle_pct = 14;
    // floor above zero
    run_phase(12, 4, 8, 1000, 100, 0);
    for (int k = 0; k < 5; k++)
      run_phase($urandom_range(4095), $urandom_range(4095), $urandom_range(255),
                -int'($urandom_range(16384)), 100, 0);

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
